/* src/pps_pkg.sv */
// Package: shared types, constants and codes for the paced poll list scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int LEN_W       = 6;
    localparam int TIME_W      = 32;
    localparam int PID_W       = 8;
    localparam int SPACE_W     = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_ENTRIES);
    localparam logic [SPACE_W-1:0] SPACE_MIN = SPACE_W'(1);
    localparam logic [SPACE_W-1:0] SPACE_MAX = SPACE_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_INTERVAL  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_SPACING = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_FILTER   = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_SEND  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TIME_W-1:0] now_ms;
        logic              prio_pending;
        logic              send_ok;
        logic [SLOT_W-1:0] slot_index;
        logic [PID_W-1:0]  slot_pid;
        logic              slot_supported;
        logic              slot_enabled;
    } in_beat_t;

    typedef struct packed {
        logic             request_valid;
        logic [PID_W-1:0] request_pid;
        logic             awaiting_send;
    } out_beat_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic             supported;
        logic             enabled;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CYC_CHK,
        ST_SPC_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PEND_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic start_cycle;
        logic step_slot;
        logic offer;
        logic send_done;
        logic end_cycle;
        logic tbl_write;
        logic res_set;
        logic res_offer;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       prio_pending;
        logic       offer_pending;
        logic       in_cycle;
        logic       interval_met;
        logic       spacing_block;
        logic       left_zero;
        logic       skip;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/paced_poll_list_scheduler.sv */
// Top level: paced round-robin poll list scheduler with config port and output register.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat at a time on the input channel and returns exactly
// one result beat for each. A poll beat with no priority traffic and no offer
// waiting checks the cycle interval (when no polling cycle is open) and the
// request spacing, then scans the list one slot at a time, each visit a table
// read state and then a skip test state, and offers the first slot that it does
// not skip. A scan passes over at most the list length, capped at 32 slots; a
// poll that runs off the end of the list closes the polling cycle. A poll
// stopped by the interval or the spacing, a re-offer of a waiting slot, and
// send-done, entry-write, blocked and ignored beats skip the scan. Results sit
// in an output register, so a stalled consumer holds only the next beat, never
// the finished one. The table has no reset: write every slot that the list
// length covers before polling. Configuration writes are always ready and must
// come only while the block is idle.
module paced_poll_list_scheduler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire pps_pkg::in_beat_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output pps_pkg::out_beat_t                  out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pps_pkg::CFG_DATA_W-1:0] cfg_data
);

    pps_pkg::cmd_t    cmd;
    pps_pkg::status_t st;

    // config writes land directly in the registers, so never stall them
    assign cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

`ifndef SYNTHESIS
    // an offered identifier always leaves the offer pending
    a_offer_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.request_valid |-> out_data.awaiting_send)
        else $error("offer delivered without pending flag");

    // with no offer the identifier field is zero
    a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.request_valid |-> out_data.request_pid == '0)
        else $error("non-zero pid on empty result");

    // one item in flight: after a beat is taken, hold off the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");
`endif

endmodule

`default_nettype wire

/* src/pps_ctrl.sv */
// Controller: sequences one item at a time through decode, checks, slot scan and result.
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pps_pkg::status_t st,
    output pps_pkg::cmd_t         cmd
);

    pps_pkg::state_t state_reg;
    pps_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pps_pkg::ST_DISPATCH;
                end
            end
            pps_pkg::ST_DISPATCH:
            begin
                unique case (st.operation)
                    pps_pkg::OP_POLL:
                    begin
                        if (st.prio_pending)
                        begin
                            cmd.res_set = 1'b1;
                            state_next  = pps_pkg::ST_EMIT;
                        end
                        else if (st.offer_pending)
                        begin
                            state_next = pps_pkg::ST_PEND_RD;
                        end
                        else if (!st.in_cycle)
                        begin
                            state_next = pps_pkg::ST_CYC_CHK;
                        end
                        else
                        begin
                            state_next = pps_pkg::ST_SPC_CHK;
                        end
                    end
                    pps_pkg::OP_SEND:
                    begin
                        cmd.send_done = 1'b1;
                        cmd.res_set   = 1'b1;
                        state_next    = pps_pkg::ST_EMIT;
                    end
                    pps_pkg::OP_WRITE:
                    begin
                        cmd.tbl_write = 1'b1;
                        cmd.res_set   = 1'b1;
                        state_next    = pps_pkg::ST_EMIT;
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                        state_next  = pps_pkg::ST_EMIT;
                    end
                endcase
            end
            pps_pkg::ST_CYC_CHK:
            begin
                if (st.interval_met)
                begin
                    cmd.start_cycle = 1'b1;
                    state_next      = pps_pkg::ST_SPC_CHK;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    state_next  = pps_pkg::ST_EMIT;
                end
            end
            pps_pkg::ST_SPC_CHK:
            begin
                if (st.spacing_block)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = pps_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = pps_pkg::ST_SCAN_RD;
                end
            end
            pps_pkg::ST_SCAN_RD:
            begin
                // table read of the current slot lands at this edge
                if (st.left_zero)
                begin
                    cmd.end_cycle = 1'b1;
                    cmd.res_set   = 1'b1;
                    state_next    = pps_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = pps_pkg::ST_SCAN_CHK;
                end
            end
            pps_pkg::ST_SCAN_CHK:
            begin
                if (st.skip)
                begin
                    cmd.step_slot = 1'b1;
                    state_next    = pps_pkg::ST_SCAN_RD;
                end
                else
                begin
                    cmd.offer     = 1'b1;
                    cmd.res_set   = 1'b1;
                    cmd.res_offer = 1'b1;
                    state_next    = pps_pkg::ST_EMIT;
                end
            end
            pps_pkg::ST_PEND_RD:
            begin
                cmd.res_set   = 1'b1;
                cmd.res_offer = 1'b1;
                state_next    = pps_pkg::ST_EMIT;
            end
            pps_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/pps_dp.sv */
// Datapath: input and config registers, list table, scheduling state and result register.
`timescale 1ns / 1ps
`default_nettype none

module pps_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pps_pkg::in_beat_t                 in_data,
    input  wire logic                              cfg_valid,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output pps_pkg::out_beat_t                     out_data,
    input  wire pps_pkg::cmd_t                     cmd,
    output pps_pkg::status_t                       st
);

    // configuration
    logic [pps_pkg::LEN_W-1:0]   list_length_reg;
    logic [pps_pkg::TIME_W-1:0]  cycle_interval_reg;
    logic [pps_pkg::SPACE_W-1:0] request_spacing_reg;
    logic                        enable_filter_reg;
    logic [pps_pkg::SPACE_W-1:0] spacing_wr;

    // scheduling state
    logic [pps_pkg::SLOT_W-1:0] position_reg,  position_next;
    logic [pps_pkg::LEN_W-1:0]  left_reg,      left_next;
    logic [pps_pkg::TIME_W-1:0] cycle_start_reg, cycle_start_next;
    logic [pps_pkg::TIME_W-1:0] last_send_reg, last_send_next;
    logic [pps_pkg::TIME_W-1:0] offer_time_reg, offer_time_next;
    logic                       in_cycle_reg,  in_cycle_next;
    logic                       pending_reg,   pending_next;
    logic                       out_valid_reg, out_valid_next;

    // payload
    pps_pkg::in_beat_t  in_reg;
    pps_pkg::entry_t    mem [pps_pkg::MAX_ENTRIES];
    pps_pkg::entry_t    rd_reg;
    logic [pps_pkg::PID_W-1:0] res_pid_reg;
    logic                      res_valid_reg;
    pps_pkg::out_beat_t out_reg;

    logic [pps_pkg::LEN_W-1:0]  used_len;
    logic [pps_pkg::LEN_W-1:0]  pos_inc;
    logic [pps_pkg::SLOT_W-1:0] pos_adv;
    logic [pps_pkg::LEN_W-1:0]  left_dec;
    logic [pps_pkg::TIME_W-1:0] since_start;
    logic [pps_pkg::TIME_W-1:0] since_send;

    assign spacing_wr = (cfg_data[pps_pkg::SPACE_W-1:0] < pps_pkg::SPACE_MIN) ? pps_pkg::SPACE_MIN :
                        (cfg_data[pps_pkg::SPACE_W-1:0] > pps_pkg::SPACE_MAX) ? pps_pkg::SPACE_MAX :
                        cfg_data[pps_pkg::SPACE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg     <= '0;
            cycle_interval_reg  <= '0;
            request_spacing_reg <= pps_pkg::SPACE_MIN;
            enable_filter_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pps_pkg::CFG_LIST_LENGTH:     list_length_reg    <= cfg_data[pps_pkg::LEN_W-1:0];
                pps_pkg::CFG_CYCLE_INTERVAL:  cycle_interval_reg <= cfg_data[pps_pkg::TIME_W-1:0];
                pps_pkg::CFG_REQUEST_SPACING: request_spacing_reg <= spacing_wr;
                pps_pkg::CFG_ENABLE_FILTER:   enable_filter_reg  <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    assign used_len = (list_length_reg > pps_pkg::MAX_LEN) ? pps_pkg::MAX_LEN : list_length_reg;
    assign pos_inc  = {1'b0, position_reg} + pps_pkg::LEN_W'(1);
    assign pos_adv  = (pos_inc >= used_len) ? '0 : pos_inc[pps_pkg::SLOT_W-1:0];
    assign left_dec = (left_reg == '0) ? '0 : left_reg - pps_pkg::LEN_W'(1);

    assign since_start = in_reg.now_ms - cycle_start_reg;
    assign since_send  = in_reg.now_ms - last_send_reg;

    always_comb
    begin
        position_next    = position_reg;
        left_next        = left_reg;
        cycle_start_next = cycle_start_reg;
        last_send_next   = last_send_reg;
        offer_time_next  = offer_time_reg;
        in_cycle_next    = in_cycle_reg;
        pending_next     = pending_reg;
        if (cmd.start_cycle)
        begin
            cycle_start_next = in_reg.now_ms;
            position_next    = '0;
            left_next        = used_len;
            in_cycle_next    = 1'b1;
        end
        if (cmd.step_slot)
        begin
            position_next = pos_adv;
            left_next     = left_dec;
        end
        if (cmd.end_cycle)
        begin
            in_cycle_next = 1'b0;
        end
        if (cmd.offer)
        begin
            pending_next    = 1'b1;
            offer_time_next = in_reg.now_ms;
        end
        if (cmd.send_done && pending_reg)
        begin
            pending_next = 1'b0;
            if (in_reg.send_ok)
            begin
                position_next  = pos_adv;
                left_next      = left_dec;
                last_send_next = offer_time_reg;
                if (left_dec == '0)
                begin
                    in_cycle_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            left_reg        <= '0;
            cycle_start_reg <= '0;
            last_send_reg   <= '0;
            offer_time_reg  <= '0;
            in_cycle_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            position_reg    <= position_next;
            left_reg        <= left_next;
            cycle_start_reg <= cycle_start_next;
            last_send_reg   <= last_send_next;
            offer_time_reg  <= offer_time_next;
            in_cycle_reg    <= in_cycle_next;
            pending_reg     <= pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // table: written by entry beats, read at the current position every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            mem[in_reg.slot_index] <= '{pid:       in_reg.slot_pid,
                                        supported: in_reg.slot_supported,
                                        enabled:   in_reg.slot_enabled};
        end
        rd_reg <= mem[position_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        if (cmd.res_set)
        begin
            res_valid_reg <= cmd.res_offer;
            res_pid_reg   <= cmd.res_offer ? rd_reg.pid : '0;
        end
        if (cmd.emit)
        begin
            out_reg <= '{request_valid: res_valid_reg,
                         request_pid:   res_pid_reg,
                         awaiting_send: pending_reg};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        st.operation     = in_reg.operation;
        st.prio_pending  = in_reg.prio_pending;
        st.offer_pending = pending_reg;
        st.in_cycle      = in_cycle_reg;
        st.interval_met  = (since_start >= cycle_interval_reg);
        st.spacing_block = (last_send_reg != '0) &&
                           (since_send < {{(pps_pkg::TIME_W-pps_pkg::SPACE_W){1'b0}},
                                          request_spacing_reg});
        st.left_zero     = (left_reg == '0);
        st.skip          = !rd_reg.supported || (enable_filter_reg && !rd_reg.enabled);
        st.out_free      = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

/* test/tb_paced_poll_list_scheduler.sv */
// Testbench: self-checking stimulus and scoreboard for the paced poll list scheduler.
`timescale 1ns / 1ps

module tb_paced_poll_list_scheduler;
    import pps_pkg::*;

    // Operation code 3 carries no meaning; the block must ignore it.
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    // A poll passes over at most 32 slots, each visit a table read and a skip test.
    localparam int         SETTLE_CYCLES = 100;
    localparam int         CYCLE_LIMIT   = 1000000;

    // Scoreboard: a cycle-free copy of the scheduler, plus the queue of result
    // beats that the accepted input beats have yet to produce.
    class poll_list_scoreboard;
        entry_t               slots [MAX_ENTRIES];
        bit [MAX_ENTRIES-1:0] loaded;
        int unsigned          pos;
        int unsigned          left;
        bit [TIME_W-1:0]      cycle_start;
        bit [TIME_W-1:0]      last_send;
        bit [TIME_W-1:0]      offer_at;
        bit                   in_cycle;
        bit                   pending;
        bit [LEN_W-1:0]       len_reg;
        bit [TIME_W-1:0]      interval_reg;
        bit [SPACE_W-1:0]     spacing_reg;
        bit                   filter_reg;
        out_beat_t            replies [$];
        int unsigned          mismatches;
        int unsigned          checked;
        int unsigned          offers;

        function new();
            loaded       = '0;
            pos          = 0;
            left         = 0;
            cycle_start  = '0;
            last_send    = '0;
            offer_at     = '0;
            in_cycle     = 1'b0;
            pending      = 1'b0;
            len_reg      = '0;
            interval_reg = '0;
            spacing_reg  = SPACE_MIN;
            filter_reg   = 1'b0;
            mismatches   = 0;
            checked      = 0;
            offers       = 0;
        endfunction

        function int unsigned slots_in_use();
            return (len_reg > MAX_LEN) ? MAX_ENTRIES : int'(len_reg);
        endfunction

        // Wrap to slot 0 past the last slot in use (or at once on an empty list).
        function int unsigned step_pos(int unsigned p);
            return (p + 1 >= slots_in_use()) ? 0 : p + 1;
        endfunction

        function bit passes_over(int unsigned s);
            return !slots[s].supported || (filter_reg && !slots[s].enabled);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LIST_LENGTH:     len_reg = data[LEN_W-1:0];
                CFG_CYCLE_INTERVAL:  interval_reg = data;
                CFG_REQUEST_SPACING:
                begin
                    if (data[SPACE_W-1:0] < SPACE_MIN)
                        spacing_reg = SPACE_MIN;
                    else if (data[SPACE_W-1:0] > SPACE_MAX)
                        spacing_reg = SPACE_MAX;
                    else
                        spacing_reg = data[SPACE_W-1:0];
                end
                CFG_ENABLE_FILTER:   filter_reg = data[0];
                default: ;
            endcase
        endfunction

        function out_beat_t schedule_step(in_beat_t b);
            out_beat_t       r;
            bit [TIME_W-1:0] age;
            bit              go;
            r  = '0;
            go = 1'b1;
            case (b.operation)
                OP_POLL:
                begin
                    if (b.prio_pending)
                        go = 1'b0;
                    else if (pending)
                    begin
                        // re-offer the held slot, leave the timing alone
                        r.request_valid = 1'b1;
                        r.request_pid   = slots[pos].pid;
                        go              = 1'b0;
                    end
                    else if (!in_cycle)
                    begin
                        age = b.now_ms - cycle_start;
                        if (age < interval_reg)
                            go = 1'b0;
                        else
                        begin
                            cycle_start = b.now_ms;
                            pos         = 0;
                            left        = slots_in_use();
                            in_cycle    = 1'b1;
                        end
                    end
                    // a zero send time means nothing has gone out yet: no spacing
                    if (go && last_send != '0)
                    begin
                        age = b.now_ms - last_send;
                        if (age < spacing_reg)
                            go = 1'b0;
                    end
                    if (go)
                    begin
                        while (left > 0 && passes_over(pos))
                        begin
                            pos = step_pos(pos);
                            left--;
                        end
                        if (left == 0)
                            in_cycle = 1'b0;
                        else
                        begin
                            pending         = 1'b1;
                            offer_at        = b.now_ms;
                            r.request_valid = 1'b1;
                            r.request_pid   = slots[pos].pid;
                        end
                    end
                end
                OP_SEND:
                begin
                    if (pending)
                    begin
                        if (b.send_ok)
                        begin
                            pos = step_pos(pos);
                            if (left > 0)
                                left--;
                            last_send = offer_at;
                            if (left == 0)
                                in_cycle = 1'b0;
                        end
                        pending = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    slots[b.slot_index].pid       = b.slot_pid;
                    slots[b.slot_index].supported = b.slot_supported;
                    slots[b.slot_index].enabled   = b.slot_enabled;
                    loaded[b.slot_index]          = 1'b1;
                end
                default: ;
            endcase
            r.awaiting_send = pending;
            if (r.request_valid)
                offers++;
            return r;
        endfunction

        function void note_beat(in_beat_t b);
            replies.push_back(schedule_step(b));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            checked++;
            if (replies.size() == 0)
            begin
                flag($sformatf("result beat with nothing due: valid=%0b pid=%02h awaiting=%0b",
                               got.request_valid, got.request_pid, got.awaiting_send));
                return;
            end
            want = replies.pop_front();
            if (got.request_valid !== want.request_valid ||
                got.request_pid !== want.request_pid ||
                got.awaiting_send !== want.awaiting_send)
                flag($sformatf({"result %0d: expected valid=%0b pid=%02h awaiting=%0b, ",
                                "got valid=%0b pid=%02h awaiting=%0b"}, checked,
                               want.request_valid, want.request_pid, want.awaiting_send,
                               got.request_valid, got.request_pid, got.awaiting_send));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    poll_list_scoreboard   sb;
    bit                    calm;        // set: neither side idles
    bit [TIME_W-1:0]       tick_ms;     // the millisecond clock carried by the beats
    int unsigned           beats_sent;
    int unsigned           settings;
    int unsigned           cycles;

    paced_poll_list_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check every accepted result beat and stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                sb.check_beat(out_data);
            out_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                 sb.replies.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic in_beat_t beat(logic [1:0] op, logic [TIME_W-1:0] now, logic primary,
                                      logic ok, logic [SLOT_W-1:0] idx, logic [PID_W-1:0] pid,
                                      logic sup, logic en);
        in_beat_t b;
        b.operation      = op;
        b.now_ms         = now;
        b.prio_pending   = primary;
        b.send_ok        = ok;
        b.slot_index     = idx;
        b.slot_pid       = pid;
        b.slot_supported = sup;
        b.slot_enabled   = en;
        return b;
    endfunction

    // Hold valid and the payload until the beat is taken; idle before it at random.
    // Valid is only lowered in a step where it is not raised again.
    task automatic put_beat(input in_beat_t b);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(b);
        beats_sent++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every due result, then let the block fall quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] len_data,
                             input logic [CFG_DATA_W-1:0] interval,
                             input logic [CFG_DATA_W-1:0] spacing_data,
                             input logic [CFG_DATA_W-1:0] filter_data,
                             input int unsigned count, input bit quiet);
        in_beat_t    b;
        logic [63:0] raw;
        logic [1:0]  op;
        int unsigned need;
        int unsigned pick;
        settle();
        put_reg(CFG_LIST_LENGTH, len_data);
        put_reg(CFG_CYCLE_INTERVAL, interval);
        put_reg(CFG_REQUEST_SPACING, spacing_data);
        put_reg(CFG_ENABLE_FILTER, filter_data);
        settings++;
        calm = quiet;
        // Load every slot in use that has never been written before any poll reads it.
        need = (len_data[LEN_W-1:0] > MAX_LEN) ? MAX_ENTRIES : int'(len_data[LEN_W-1:0]);
        for (int s = 0; s < need; s++)
        begin
            if (!sb.loaded[s])
                put_beat(beat(OP_WRITE, tick_ms, 1'b0, 1'b0, SLOT_W'(s), PID_W'($urandom),
                              ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1))));
        end
        repeat (count)
        begin
            raw = {$urandom, $urandom};
            b   = raw[$bits(in_beat_t)-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 85)
                tick_ms += $urandom_range(0, 3);
            else if (pick < 97)
                tick_ms += $urandom_range(0, 120);
            else
                tick_ms = $urandom;
            b.now_ms       = tick_ms;
            b.prio_pending = ($urandom_range(0, 99) < 8);
            // Mostly well-formed: answer an offer with its send-done, otherwise poll.
            pick = $urandom_range(0, 99);
            if (sb.pending)
                op = (pick < 65) ? OP_SEND : (pick < 95) ? OP_POLL :
                     (pick < 98) ? OP_WRITE : OP_UNUSED;
            else
                op = (pick < 82) ? OP_POLL : (pick < 90) ? OP_WRITE :
                     (pick < 96) ? OP_SEND : OP_UNUSED;
            b.operation = op;
            if (op == OP_SEND)
                b.send_ok = ($urandom_range(0, 99) < 80);
            put_beat(b);
        end
    endtask

    initial
    begin
        sb         = new();
        calm       = 1'b0;
        tick_ms    = '0;
        beats_sent = 0;
        settings   = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty list, so a poll opens and closes a cycle at once.
        put_beat(beat(OP_POLL, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        // send-done with nothing on offer: drop it
        put_beat(beat(OP_SEND, 32'h0, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd31, 8'hFF, 1'b1, 1'b1));
        put_beat(beat(OP_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        // Slot 0 unsupported, slot 1 disabled, slots 2 and 3 usable, slot 31 the top.
        put_beat(beat(OP_WRITE, 32'h0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b1));
        put_beat(beat(OP_WRITE, 32'h0, 1'b0, 1'b0, 5'd1, 8'hA5, 1'b1, 1'b0));
        put_beat(beat(OP_WRITE, 32'h0, 1'b0, 1'b0, 5'd2, 8'h5A, 1'b1, 1'b1));
        put_beat(beat(OP_WRITE, 32'h0, 1'b0, 1'b0, 5'd3, 8'hFF, 1'b1, 1'b1));
        put_beat(beat(OP_WRITE, 32'h0, 1'b0, 1'b0, 5'd31, 8'h3C, 1'b1, 1'b0));

        // Four slots, filtering on, spacing written as zero (held at one).
        settle();
        put_reg(CFG_LIST_LENGTH, 32'd4);
        put_reg(CFG_CYCLE_INTERVAL, 32'd0);
        put_reg(CFG_REQUEST_SPACING, 32'd0);
        put_reg(CFG_ENABLE_FILTER, 32'd1);
        settings++;
        put_beat(beat(OP_POLL, 32'd0, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        // skip slots 0 and 1, offer slot 2; then re-offer while it waits
        put_beat(beat(OP_POLL, 32'd0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_POLL, 32'd0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_SEND, 32'd0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_POLL, 32'd0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        // success at time zero leaves the send time at zero: no spacing applies
        put_beat(beat(OP_SEND, 32'd0, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_POLL, 32'd0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        // last slot sent: position wraps and the cycle ends
        put_beat(beat(OP_SEND, 32'd0, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_POLL, 32'd5, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_SEND, 32'd5, 1'b0, 1'b1, 5'd0, 8'h00, 1'b0, 1'b0));
        // too soon after the last send
        put_beat(beat(OP_POLL, 32'd5, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        // time wrapped all the way round
        put_beat(beat(OP_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));
        put_beat(beat(OP_SEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 1'b0));

        // Random traffic under a run of settings, extremes first; the first phase
        // runs without any idling on either side.
        tick_ms = 32'd100;
        run_phase(32'd8, 32'd0, 32'd1, 32'd0, 75, 1'b1);
        run_phase(32'd32, 32'd20, 32'd127, 32'd1, 75, 1'b0);
        tick_ms = 32'hFFFF_FFC0;
        run_phase(32'd63, 32'hFFFF_FFFF, 32'd0, 32'd0, 40, 1'b0);
        run_phase(32'd1, 32'd3, 32'd2, 32'd1, 60, 1'b0);
        run_phase(32'd0, 32'd0, 32'd50, 32'd0, 40, 1'b0);
        run_phase(32'd32, 32'd0, 32'd100, 32'd0, 80, 1'b0);
        repeat (4)
        begin
            // upper data bits are random: the block must mask them off
            run_phase(($urandom & ~32'h3F) | $urandom_range(0, 63), $urandom_range(0, 40),
                      ($urandom & ~32'h7F) | $urandom_range(0, 127), $urandom, 60, 1'b0);
        end
        settle();

        $display("Run covered %0d input beats under %0d register settings", beats_sent,
                 settings);
        $display("%0d result beats checked, %0d offers among them, %0d mismatches",
                 sb.checked, sb.offers, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
src/pps_pkg.sv
src/pps_ctrl.sv
src/pps_dp.sv
src/paced_poll_list_scheduler.sv
test/tb_paced_poll_list_scheduler.sv
